### src/cmap_pkg.sv
// Shared constants and types for the cell ownership map.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package cmap_pkg;

    localparam int CODE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int START_W  = 7;
    localparam int LEN_W    = 8;
    localparam int HOLE_W   = 7;
    localparam int PROC_W   = 8;
    localparam int PCT_W    = 7;

    localparam int DEF_NUM_CELLS = 128;
    localparam int PCT_SCALE     = 100;

    localparam logic [CODE_W-1:0] FREE_CODE = 8'h20;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NOP    = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [START_W-1:0] start_cell;
        logic [LEN_W-1:0]   run_length;
        logic [CODE_W-1:0]  owner_id;
    } op_t;

    typedef struct packed {
        logic init;
        logic step;
    } walk_ctl_t;

endpackage

`default_nettype wire

### src/cmap_cell.sv
// One storage cell of the map ring: an owner code that moves to its neighbor.
// Depends on cmap_pkg.
`default_nettype none

module cmap_cell (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        shift_en,
    input  wire logic [cmap_pkg::CODE_W-1:0] d_in,
    output logic      [cmap_pkg::CODE_W-1:0] q_out
);
    import cmap_pkg::*;

    logic [CODE_W-1:0] code_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_reg <= FREE_CODE;
        end else if (shift_en) begin
            code_reg <= d_in;
        end
    end

    assign q_out = code_reg;

endmodule

`default_nettype wire

### src/cmap_walk.sv
// Per-cell update and run statistics for the cell leaving the head of the ring.
// Depends on cmap_pkg.
`default_nettype none

module cmap_walk #(
    parameter int NUM_CELLS = cmap_pkg::DEF_NUM_CELLS,
    localparam int IDX_W = $clog2(NUM_CELLS),
    localparam int CNT_W = $clog2(NUM_CELLS + 1)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire cmap_pkg::walk_ctl_t         ctl,
    input  wire cmap_pkg::op_t               op,
    input  wire logic [IDX_W-1:0]            idx,
    input  wire logic [cmap_pkg::CODE_W-1:0] head_code,
    output logic      [cmap_pkg::CODE_W-1:0] new_code,
    output logic      [CNT_W-1:0]            hole_cnt,
    output logic      [CNT_W-1:0]            proc_cnt,
    output logic      [CNT_W-1:0]            used_cnt,
    output logic                             collision,
    output logic                             range_error
);
    import cmap_pkg::*;

    localparam int XW = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;

    op_t               op_reg;
    logic              range_err_reg;
    logic              coll_reg;
    logic              in_hole_reg;
    logic [CODE_W-1:0] prev_reg;
    logic [CNT_W-1:0]  hole_cnt_reg;
    logic [CNT_W-1:0]  proc_cnt_reg;
    logic [CNT_W-1:0]  used_cnt_reg;

    logic [XW-1:0]     run_end;
    logic [XW-1:0]     op_end;
    logic              in_run;
    logic              coll_hit;
    logic              is_free;

    // end of the requested run, for the range check at accept
    assign op_end  = XW'(op.start_cell) + XW'(op.run_length);
    assign run_end = XW'(op_reg.start_cell) + XW'(op_reg.run_length);
    assign in_run  = (XW'(idx) >= XW'(op_reg.start_cell)) && (XW'(idx) < run_end);

    always_comb begin
        new_code = head_code;
        coll_hit = 1'b0;
        unique case (op_reg.kind)
            KIND_INSERT: begin
                if (!range_err_reg && in_run) begin
                    if (head_code != FREE_CODE) begin
                        coll_hit = 1'b1;
                    end else begin
                        new_code = op_reg.owner_id;
                    end
                end
            end
            KIND_DELETE: begin
                if (head_code == op_reg.owner_id) begin
                    new_code = FREE_CODE;
                end
            end
            KIND_CLEAR: begin
                new_code = FREE_CODE;
            end
            KIND_NOP: begin
            end
            default: begin
            end
        endcase
    end

    assign is_free = (new_code == FREE_CODE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg        <= '0;
            range_err_reg <= 1'b0;
            coll_reg      <= 1'b0;
            in_hole_reg   <= 1'b0;
            prev_reg      <= FREE_CODE;
            hole_cnt_reg  <= '0;
            proc_cnt_reg  <= '0;
            used_cnt_reg  <= '0;
        end else if (ctl.init) begin
            op_reg        <= op;
            range_err_reg <= (op.kind == KIND_INSERT) && (op_end > XW'(NUM_CELLS));
            coll_reg      <= 1'b0;
            in_hole_reg   <= 1'b0;
            prev_reg      <= FREE_CODE;
            hole_cnt_reg  <= '0;
            proc_cnt_reg  <= '0;
            used_cnt_reg  <= '0;
        end else if (ctl.step) begin
            if (coll_hit) begin
                coll_reg <= 1'b1;
            end
            if (is_free) begin
                if (!in_hole_reg) begin
                    hole_cnt_reg <= hole_cnt_reg + CNT_W'(1);
                end
                in_hole_reg <= 1'b1;
            end else begin
                in_hole_reg  <= 1'b0;
                used_cnt_reg <= used_cnt_reg + CNT_W'(1);
                if (new_code != prev_reg) begin
                    proc_cnt_reg <= proc_cnt_reg + CNT_W'(1);
                end
            end
            prev_reg <= new_code;
        end
    end

    assign hole_cnt    = hole_cnt_reg;
    assign proc_cnt    = proc_cnt_reg;
    assign used_cnt    = used_cnt_reg;
    assign collision   = coll_reg;
    assign range_error = range_err_reg;

endmodule

`default_nettype wire

### src/cmap_pct.sv
// Percent-full unit: used*100 over the cell count by reciprocal multiplication,
// registered when start is high. Depends on cmap_pkg.
`default_nettype none

module cmap_pct #(
    parameter int NUM_CELLS = cmap_pkg::DEF_NUM_CELLS,
    localparam int CNT_W = $clog2(NUM_CELLS + 1)
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [CNT_W-1:0]           used,
    output logic      [cmap_pkg::PCT_W-1:0] quotient
);
    import cmap_pkg::*;

    // used*100 stays below 2^X_W; a reciprocal rounded up with X_W + log2(cells)
    // fraction bits gives the exact floor over that whole range
    localparam int     X_W    = $clog2(NUM_CELLS * PCT_SCALE + 1);
    localparam int     SHIFT  = X_W + $clog2(NUM_CELLS);
    localparam int     P_W    = 2 * X_W + 1;
    localparam longint RECIP  = ((longint'(1) << SHIFT) + longint'(NUM_CELLS) - 1)
                                / longint'(NUM_CELLS);
    localparam longint FACTOR = longint'(PCT_SCALE) * RECIP;

    logic [P_W-1:0]   prod;
    logic [PCT_W-1:0] q_reg;

    assign prod = P_W'(used) * P_W'(FACTOR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= '0;
        end else if (start) begin
            q_reg <= PCT_W'(prod >> SHIFT);
        end
    end

    assign quotient = q_reg;

endmodule

`default_nettype wire

### src/cell_ownership_map_with_stats_top.sv
// Requests are taken one at a time: the ring of cells rotates once per request
// through one update unit, then the percent unit registers the percentage.
// s_ready is high whenever the ring is idle, even while a result waits on m_ready.
// Reset (aresetn low, synchronous) frees every cell and drops m_valid.
// Depends on cmap_pkg, cmap_cell, cmap_walk, cmap_pct.
`default_nettype none

module cell_ownership_map_with_stats_top #(
    parameter int NUM_CELLS = cmap_pkg::DEF_NUM_CELLS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [cmap_pkg::KIND_W-1:0]  s_kind,
    input  wire logic [cmap_pkg::START_W-1:0] s_start_cell,
    input  wire logic [cmap_pkg::LEN_W-1:0]   s_run_length,
    input  wire logic [cmap_pkg::CODE_W-1:0]  s_owner_id,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [cmap_pkg::HOLE_W-1:0]  m_hole_count,
    output logic      [cmap_pkg::PROC_W-1:0]  m_process_count,
    output logic      [cmap_pkg::PCT_W-1:0]   m_percent_full,
    output logic                              m_collision,
    output logic                              m_range_error
);
    import cmap_pkg::*;

    localparam int IDX_W = $clog2(NUM_CELLS);
    localparam int CNT_W = $clog2(NUM_CELLS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_START,
        ST_DIV
    } state_t;

    state_t            state_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              m_valid_reg;
    logic [HOLE_W-1:0] m_hole_reg;
    logic [PROC_W-1:0] m_proc_reg;
    logic [PCT_W-1:0]  m_pct_reg;
    logic              m_coll_reg;
    logic              m_rerr_reg;

    logic              accept;
    logic              out_free;
    logic              result_load;
    op_t               s_op;
    walk_ctl_t         walk_ctl;
    logic [CODE_W-1:0] cell_q [NUM_CELLS];
    logic [CODE_W-1:0] new_code;
    logic [CNT_W-1:0]  hole_cnt;
    logic [CNT_W-1:0]  proc_cnt;
    logic [CNT_W-1:0]  used_cnt;
    logic              walk_coll;
    logic              walk_rerr;
    logic [PCT_W-1:0]  pct_q;

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign result_load = (state_reg == ST_DIV) && out_free;

    always_comb begin
        s_op.kind       = s_kind;
        s_op.start_cell = s_start_cell;
        s_op.run_length = s_run_length;
        s_op.owner_id   = s_owner_id;
        walk_ctl.init   = accept;
        walk_ctl.step   = (state_reg == ST_WALK);
    end

    // Ring: the head cell goes through the update unit and re-enters at the tail,
    // so after NUM_CELLS shifts every cell is back in place.
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        if (k == NUM_CELLS - 1) begin : g_tail
            cmap_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (walk_ctl.step),
                .d_in     (new_code),
                .q_out    (cell_q[k])
            );
        end else begin : g_body
            cmap_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (walk_ctl.step),
                .d_in     (cell_q[k+1]),
                .q_out    (cell_q[k])
            );
        end
    end

    cmap_walk #(
        .NUM_CELLS (NUM_CELLS)
    ) u_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (walk_ctl),
        .op          (s_op),
        .idx         (idx_reg),
        .head_code   (cell_q[0]),
        .new_code    (new_code),
        .hole_cnt    (hole_cnt),
        .proc_cnt    (proc_cnt),
        .used_cnt    (used_cnt),
        .collision   (walk_coll),
        .range_error (walk_rerr)
    );

    cmap_pct #(
        .NUM_CELLS (NUM_CELLS)
    ) u_pct (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_START),
        .used     (used_cnt),
        .quotient (pct_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            m_hole_reg  <= '0;
            m_proc_reg  <= '0;
            m_pct_reg   <= '0;
            m_coll_reg  <= 1'b0;
            m_rerr_reg  <= 1'b0;
        end else begin
            if (result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        idx_reg   <= '0;
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (idx_reg == IDX_W'(NUM_CELLS - 1)) begin
                        state_reg <= ST_START;
                    end else begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                ST_START: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    // hold the result until the output register is free
                    if (result_load) begin
                        m_hole_reg  <= HOLE_W'(hole_cnt);
                        m_proc_reg  <= PROC_W'(proc_cnt);
                        m_pct_reg   <= pct_q;
                        m_coll_reg  <= walk_coll;
                        m_rerr_reg  <= walk_rerr;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_hole_count    = m_hole_reg;
    assign m_process_count = m_proc_reg;
    assign m_percent_full  = m_pct_reg;
    assign m_collision     = m_coll_reg;
    assign m_range_error   = m_rerr_reg;

endmodule

`default_nettype wire

### src/cmap_check.sv
// Port-level checks for the cell ownership map, bound to the top level.
// Depends on cmap_pkg and cell_ownership_map_with_stats_top.
`default_nettype none

module cmap_check (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic [cmap_pkg::HOLE_W-1:0]  m_hole_count,
    input wire logic [cmap_pkg::PROC_W-1:0]  m_process_count,
    input wire logic [cmap_pkg::PCT_W-1:0]   m_percent_full,
    input wire logic                         m_collision,
    input wire logic                         m_range_error
);
    import cmap_pkg::*;

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hole_count)
            && $stable(m_process_count) && $stable(m_percent_full)
            && $stable(m_collision) && $stable(m_range_error))
        else $error("result changed while stalled");

    // one request at a time: the ring is busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while the ring was walking");

    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_percent_full <= PCT_W'(PCT_SCALE))
        else $error("percent full above 100");

    // a rejected insert writes nothing, so it cannot collide
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_range_error && m_collision))
        else $error("range error and collision both set");

endmodule

bind cell_ownership_map_with_stats_top cmap_check u_cmap_check (.*);

`default_nettype wire

### tb/sv/cmap_mirror_pkg.sv
// Cell map mirror for the testbench: keeps its own copy of the 128 owner codes and
// the queue of statistics still due from the block. Depends on cmap_pkg.
`timescale 1ns / 1ps

package cmap_mirror_pkg;

    import cmap_pkg::*;

    localparam int MAP_CELLS = DEF_NUM_CELLS;

    typedef struct packed {
        logic [HOLE_W-1:0] hole_count;
        logic [PROC_W-1:0] process_count;
        logic [PCT_W-1:0]  percent_full;
        logic              collision;
        logic              range_error;
    } map_stats_t;

    class ownership_mirror;
        logic [CODE_W-1:0] cells [MAP_CELLS];
        map_stats_t        stats_due [$];
        int unsigned       mismatches;
        int unsigned       results_seen;

        function new();
            wipe();
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void wipe();
            foreach (cells[i]) cells[i] = FREE_CODE;
        endfunction

        function int pending();
            return stats_due.size();
        endfunction

        // Apply one accepted request to the mirror and queue the statistics it yields.
        function void apply_request(logic [KIND_W-1:0] kind, int start, int len,
                                    logic [CODE_W-1:0] owner);
            map_stats_t        want;
            int unsigned       holes;
            int unsigned       procs;
            int unsigned       used;
            bit                in_free;
            bit                hit;
            bit                overrun;
            logic [CODE_W-1:0] prev;
            holes   = 0;
            procs   = 0;
            used    = 0;
            in_free = 0;
            hit     = 0;
            overrun = 0;
            prev    = FREE_CODE;
            case (kind)
                KIND_INSERT: begin
                    if (start + len > MAP_CELLS) begin
                        overrun = 1;
                    end else begin
                        // occupied cells keep their owner, only free ones are claimed
                        for (int i = start; i < start + len; i++) begin
                            if (cells[i] != FREE_CODE) hit = 1;
                            else cells[i] = owner;
                        end
                    end
                end
                KIND_DELETE: begin
                    foreach (cells[i]) if (cells[i] == owner) cells[i] = FREE_CODE;
                end
                KIND_CLEAR: wipe();
                default: ;
            endcase
            foreach (cells[i]) begin
                if (cells[i] == FREE_CODE) begin
                    if (!in_free) holes++;
                    in_free = 1;
                end else begin
                    in_free = 0;
                    used++;
                    if (cells[i] != prev) procs++;
                end
                prev = cells[i];
            end
            want.hole_count    = HOLE_W'(holes);
            want.process_count = PROC_W'(procs);
            want.percent_full  = PCT_W'((used * PCT_SCALE) / MAP_CELLS);
            want.collision     = hit;
            want.range_error   = overrun;
            stats_due.push_back(want);
        endfunction

        function void match_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_stats(map_stats_t got);
            map_stats_t want;
            results_seen++;
            if (stats_due.size() == 0) begin
                $error("result with no request outstanding");
                mismatches++;
                return;
            end
            want = stats_due.pop_front();
            match_field("hole_count", want.hole_count, got.hole_count);
            match_field("process_count", want.process_count, got.process_count);
            match_field("percent_full", want.percent_full, got.percent_full);
            match_field("collision", want.collision, got.collision);
            match_field("range_error", want.range_error, got.range_error);
        endfunction
    endclass

endpackage

### tb/sv/tb_cell_ownership_map_with_stats_top.sv
// Top-level testbench for cell_ownership_map_with_stats_top: directed and random map
// operations with random stalls on both channels. Depends on cmap_pkg, cmap_mirror_pkg.
`timescale 1ns / 1ps

module tb_cell_ownership_map_with_stats_top;

    import cmap_pkg::*;
    import cmap_mirror_pkg::*;

    localparam int RESULT_LATENCY = MAP_CELLS + 10;
    localparam int RANDOM_OPS     = 800;
    localparam int RUN_LIMIT      = 1500000;
    localparam int HOLD_OFF_SPAN  = 3000;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [KIND_W-1:0]  s_kind;
    logic [START_W-1:0] s_start_cell;
    logic [LEN_W-1:0]   s_run_length;
    logic [CODE_W-1:0]  s_owner_id;
    logic               m_valid;
    logic               m_ready;
    logic [HOLE_W-1:0]  m_hole_count;
    logic [PROC_W-1:0]  m_process_count;
    logic [PCT_W-1:0]   m_percent_full;
    logic               m_collision;
    logic               m_range_error;

    ownership_mirror    board = new();
    int unsigned        cycle_count = 0;
    logic [CODE_W-1:0]  owner_pool [6];

    cell_ownership_map_with_stats_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_start_cell   (s_start_cell),
        .s_run_length   (s_run_length),
        .s_owner_id     (s_owner_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hole_count   (m_hole_count),
        .m_process_count(m_process_count),
        .m_percent_full (m_percent_full),
        .m_collision    (m_collision),
        .m_range_error  (m_range_error)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Mostly short gaps, now and then a long one.
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    function automatic int pick_run_length(int start);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom_range(1, 8);
        if (r < 8) return $urandom_range(9, 40);
        if (r == 8) return ($urandom_range(0, 1) != 0) ? MAP_CELLS - start : 0;
        // past the last cell, but for start 0, which gets the whole map
        if (start == 0) return MAP_CELLS;
        return $urandom_range(MAP_CELLS - start + 1, MAP_CELLS);
    endfunction

    function automatic logic [CODE_W-1:0] pick_owner();
        if ($urandom_range(0, 9) != 0) return owner_pool[$urandom_range(0, 5)];
        return CODE_W'($urandom_range(0, 255));
    endfunction

    // Called right after the previous handshake; returns at the accepting edge.
    task automatic issue_op(logic [KIND_W-1:0] kind, int start, int len, int owner);
        int gap;
        gap = idle_span();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_kind       <= kind;
        s_start_cell <= START_W'(start);
        s_run_length <= LEN_W'(len);
        s_owner_id   <= CODE_W'(owner);
        s_valid      <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        board.apply_request(kind, start, len, CODE_W'(owner));
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int r;
        int start;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_kind       = KIND_INSERT;
        s_start_cell = '0;
        s_run_length = '0;
        s_owner_id   = '0;
        foreach (owner_pool[i]) begin
            do owner_pool[i] = CODE_W'($urandom_range(0, 255));
            while (owner_pool[i] == FREE_CODE);
        end
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        issue_op(KIND_INSERT, 0, 0, 8'h41);      // zero length
        issue_op(KIND_INSERT, 0, 128, 8'hFF);    // whole map
        issue_op(KIND_INSERT, 5, 3, 8'h01);      // every cell already taken
        issue_op(KIND_NOP, 0, 0, 8'h00);
        issue_op(KIND_DELETE, 0, 0, FREE_CODE);  // deleting the space code changes nothing
        issue_op(KIND_DELETE, 0, 0, 8'hFF);
        issue_op(KIND_INSERT, 127, 1, 8'h00);    // last cell, owner zero
        issue_op(KIND_INSERT, 127, 2, 8'h55);    // past the end
        issue_op(KIND_INSERT, 100, 29, 8'h55);   // one past the end
        issue_op(KIND_INSERT, 0, 1, 8'hAA);
        issue_op(KIND_INSERT, 1, 1, 8'h55);
        issue_op(KIND_INSERT, 2, 1, 8'hAA);
        issue_op(KIND_INSERT, 0, 10, FREE_CODE); // space owner over taken cells
        issue_op(KIND_INSERT, 10, 5, FREE_CODE); // space owner over free cells
        issue_op(KIND_INSERT, 64, 64, 8'h7E);
        issue_op(KIND_DELETE, 0, 0, 8'h00);
        issue_op(KIND_DELETE, 0, 0, 8'h33);      // owner not present
        issue_op(KIND_CLEAR, 0, 0, 8'h00);
        issue_op(KIND_INSERT, 127, 0, 8'h80);
        issue_op(KIND_INSERT, 0, 127, 8'h01);
        issue_op(KIND_DELETE, 0, 0, 8'h01);
        issue_op(KIND_INSERT, 126, 2, 8'hFE);
        issue_op(KIND_CLEAR, 0, 0, 8'hFF);
        drain_results();

        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n == RANDOM_OPS / 2) drain_results();
            r = $urandom_range(0, 99);
            start = $urandom_range(0, MAP_CELLS - 1);
            if (r < 60) begin
                issue_op(KIND_INSERT, start, pick_run_length(start), pick_owner());
            end else if (r < 95) begin
                issue_op(KIND_DELETE, start, $urandom_range(0, 128), pick_owner());
            end else if (r < 97) begin
                issue_op(KIND_CLEAR, start, $urandom_range(0, 128), $urandom_range(0, 255));
            end else begin
                issue_op(KIND_NOP, start, $urandom_range(0, 128), $urandom_range(0, 255));
            end
        end

        drain_results();
        repeat (RESULT_LATENCY + 20) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : result_sink
        int  stall;
        bit  held;
        stall   = 0;
        held    = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            // hold off once for a long stretch so the block backs up into its input
            if (!held && board.results_seen >= 300) begin
                held  = 1;
                stall = HOLD_OFF_SPAN;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                stall = idle_span();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_stats('{hole_count:    m_hole_count,
                                process_count: m_process_count,
                                percent_full:  m_percent_full,
                                collision:     m_collision,
                                range_error:   m_range_error});
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
